/* sv/mfe_pkg.sv */
// Shared types and constants of the monopole field evaluator.
package mfe_pkg;

    localparam int CoordW   = 32;
    localparam int OutW     = 48;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_STRENGTH = 3'd3;

    localparam logic [CfgDataW-1:0] STRENGTH_RESET = 32'd65536;

    localparam int KW = 29;
    localparam logic [KW-1:0] INV4PI_Q32 = 29'd341782638;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
    } mfe_in_t;

    typedef struct packed {
        logic signed [OutW-1:0] coef_x;
        logic signed [OutW-1:0] coef_y;
        logic signed [OutW-1:0] coef_z;
        logic signed [OutW-1:0] pressure_x;
        logic signed [OutW-1:0] pressure_y;
        logic signed [OutW-1:0] pressure_z;
        logic signed [OutW-1:0] grad_xx;
        logic signed [OutW-1:0] grad_yy;
        logic signed [OutW-1:0] grad_zz;
        logic signed [OutW-1:0] grad_xy;
        logic signed [OutW-1:0] grad_xz;
        logic signed [OutW-1:0] grad_yz;
    } mfe_out_t;

endpackage

/* sv/mfe_delay.sv */
// Enabled delay line for data with a reset valid bit alongside.
module mfe_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         valid_in,
    input  logic [W-1:0] data_in,
    output logic         valid_out,
    output logic [W-1:0] data_out
);

    logic [W-1:0] data_reg  [DEPTH];
    logic         valid_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= valid_in;
            for (int i = 1; i < DEPTH; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= data_in;
            for (int i = 1; i < DEPTH; i++) data_reg[i] <= data_reg[i-1];
        end
    end

    assign valid_out = valid_reg[DEPTH-1];
    assign data_out  = data_reg[DEPTH-1];

endmodule

/* sv/mfe_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module mfe_isqrt #(
    parameter int IN_W   = 66,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                valid_in,
    input  logic [IN_W-1:0]     x_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid_out,
    output logic [IN_W/2-1:0]   root_out,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STAGES = ROOT_W;

    logic [IN_W-1:0]   x_reg     [STAGES];
    logic [REM_W-1:0]  rem_reg   [STAGES];
    logic [ROOT_W-1:0] root_reg  [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];
    logic              valid_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [IN_W-1:0]   x_src;
        logic [REM_W-1:0]  rem_src;
        logic [ROOT_W-1:0] root_src;
        logic [SIDE_W-1:0] side_src;
        logic              valid_src;
        logic [REM_W:0]    t;
        logic [REM_W:0]    trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0) begin : g_first
            assign x_src     = x_in;
            assign rem_src   = '0;
            assign root_src  = '0;
            assign side_src  = side_in;
            assign valid_src = valid_in;
        end else begin : g_rest
            assign x_src     = x_reg[s-1];
            assign rem_src   = rem_reg[s-1];
            assign root_src  = root_reg[s-1];
            assign side_src  = side_reg[s-1];
            assign valid_src = valid_reg[s-1];
        end

        always_comb begin
            t         = {rem_src[REM_W-2:0], x_src[IN_W-1:IN_W-2]};
            trial     = (REM_W+1)'({root_src, 2'b01});
            ge        = (t >= trial);
            rem_next  = ge ? REM_W'(t - trial) : REM_W'(t);
            root_next = {root_src[ROOT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]    <= x_src << 2;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_src;
            end
        end
    end

    assign valid_out = valid_reg[STAGES-1];
    assign root_out  = root_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

/* sv/mfe_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module mfe_div #(
    parameter int NUM_W  = 63,
    parameter int DEN_W  = 33,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [Q_W-1:0]    q_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int WK_W = DEN_W + Q_W;

    logic [WK_W-1:0]   wk_reg    [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];
    logic              valid_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [WK_W-1:0]   wk_src;
        logic [DEN_W-1:0]  den_src;
        logic [SIDE_W-1:0] side_src;
        logic              valid_src;
        logic [DEN_W:0]    t;
        logic              ge;
        logic [DEN_W:0]    r;
        logic [WK_W-1:0]   wk_next;

        if (s == 0) begin : g_first
            assign wk_src    = WK_W'(num_in);
            assign den_src   = den_in;
            assign side_src  = side_in;
            assign valid_src = valid_in;
        end else begin : g_rest
            assign wk_src    = wk_reg[s-1];
            assign den_src   = den_reg[s-1];
            assign side_src  = side_reg[s-1];
            assign valid_src = valid_reg[s-1];
        end

        always_comb begin
            t       = wk_src[WK_W-1:Q_W-1];
            ge      = (t >= {1'b0, den_src});
            r       = ge ? (t - {1'b0, den_src}) : t;
            wk_next = {r[DEN_W-1:0], wk_src[Q_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                wk_reg[s]   <= wk_next;
                den_reg[s]  <= den_src;
                side_reg[s] <= side_src;
            end
        end
    end

    assign valid_out = valid_reg[Q_W-1];
    assign q_out     = wk_reg[Q_W-1][Q_W-1:0];
    assign side_out  = side_reg[Q_W-1];

endmodule

/* sv/monopole_field_evaluator_core.sv */
// Monopole field evaluator top level: distance, root, unit vector, coefficients, gradient.
// Takes one query point per clock while the output is not stalled and returns one result
// per point; the deepest parts are the bitwise square-root pipeline (33 stages)
// and the long-division pipelines for the unit vector (31), the coefficients (47) and
// the gradient (48), all of which accept a new operand every cycle unless stalled. A stalled result
// holds the whole pipeline in place; nothing is dropped. Configuration writes are taken
// every cycle and must only be made while no point is in flight.
module monopole_field_evaluator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mfe_pkg::mfe_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mfe_pkg::mfe_out_t                 m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mfe_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [mfe_pkg::CfgDataW-1:0]      cfg_data
);

    localparam int CW      = mfe_pkg::CoordW;
    localparam int OW      = mfe_pkg::OutW;
    localparam int KW      = mfe_pkg::KW;
    localparam int RW      = CW + 1;
    localparam int SqW     = 2 * RW;
    localparam int NW      = SqW / 2;
    localparam int MW      = 31;
    localparam int RbNumW  = RW + 30;
    localparam int MkW     = MW + KW;
    localparam int CDenW   = NW + 14;
    localparam int CQW     = 47;
    localparam int PmagW   = 2 * MW;
    localparam int QW      = PmagW - 29;
    localparam int MmagW   = 32;
    localparam int GkW     = CW + KW;
    localparam int GlW     = 30 + MmagW;
    localparam int GhW     = (GkW - 30) + MmagW;
    localparam int GNumW   = 92;
    localparam int GDenW   = 2 * NW + 6;
    localparam int GQW     = 48;
    localparam int PlW     = CW + 24;
    localparam int PhW     = CW + (CQW - 24);
    localparam int PsumW   = PhW + 25;
    localparam int MagW    = 64;
    localparam int SideW   = 1 + 3 * RW + 3;
    localparam int DlyW    = 3 * (CQW + MagW + 1);

    localparam logic [MagW-1:0] SatPos = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [MagW-1:0] SatNeg = 64'h0000_8000_0000_0000;

    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    function automatic logic [OW-1:0] sat_pack(input logic neg, input logic [MagW-1:0] mag);
        logic [MagW-1:0] lim;
        if (neg) begin
            lim      = (mag > SatNeg) ? SatNeg : mag;
            sat_pack = OW'(-lim);
        end else begin
            lim      = (mag > SatPos) ? SatPos : mag;
            sat_pack = OW'(lim);
        end
    endfunction

    // configuration
    logic [CW-1:0] center_reg [3];
    logic [CW-1:0] strength_reg;
    logic [CW-1:0] smag_reg;
    logic          sneg_reg;
    logic [GkW-1:0] gk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            strength_reg  <= mfe_pkg::STRENGTH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                mfe_pkg::CFG_CENTER_X: center_reg[0] <= cfg_data;
                mfe_pkg::CFG_CENTER_Y: center_reg[1] <= cfg_data;
                mfe_pkg::CFG_CENTER_Z: center_reg[2] <= cfg_data;
                mfe_pkg::CFG_STRENGTH: strength_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sneg_reg <= strength_reg[CW-1];
        smag_reg <= strength_reg[CW-1] ? CW'(-strength_reg) : strength_reg;
        gk_reg   <= GkW'(smag_reg) * GkW'(mfe_pkg::INV4PI_Q32);
    end

    assign cfg_ready = 1'b1;

    logic en;
    logic out_valid_reg;
    mfe_pkg::mfe_out_t out_data_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // S1: offset from the centre
    logic [CW-1:0] pt [3];
    logic [RW-1:0] r  [3];
    assign pt[0] = s_data.point_x;
    assign pt[1] = s_data.point_y;
    assign pt[2] = s_data.point_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r[i] = {pt[i][CW-1], pt[i]} - {center_reg[i][CW-1], center_reg[i]};
        end
    end

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [RW-1:0] s1_ar_reg [3];
    logic [RW-1:0] s2_ar_reg [3];
    logic [RW-1:0] s3_ar_reg [3];
    logic [2:0]    s1_nr_reg, s2_nr_reg, s3_nr_reg;
    logic [SqW-1:0] s2_sq_reg [3];
    logic [SqW-1:0] s3_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_ar_reg[i] <= r[i][RW-1] ? RW'(-r[i]) : r[i];
                s1_nr_reg[i] <= r[i][RW-1];
                s2_sq_reg[i] <= SqW'(s1_ar_reg[i]) * SqW'(s1_ar_reg[i]);
                s2_ar_reg[i] <= s1_ar_reg[i];
                s3_ar_reg[i] <= s2_ar_reg[i];
            end
            s2_nr_reg  <= s1_nr_reg;
            s3_nr_reg  <= s2_nr_reg;
            s3_sum_reg <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        end
    end

    // square root
    logic             sq_valid;
    logic [NW-1:0]    sq_root;
    logic [SideW-1:0] sq_side;

    mfe_isqrt #(.IN_W(SqW), .SIDE_W(SideW)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s3_valid_reg),
        .x_in      (s3_sum_reg),
        .side_in   ({s3_ar_reg[0], s3_ar_reg[1], s3_ar_reg[2], s3_nr_reg, 1'b0}),
        .valid_out (sq_valid),
        .root_out  (sq_root),
        .side_out  (sq_side)
    );

    logic [RW-1:0] sq_ar [3];
    logic [2:0]    sq_nr;
    logic          sq_pad;
    logic [NW-1:0] n_clamped;
    assign {sq_ar[0], sq_ar[1], sq_ar[2], sq_nr, sq_pad} = sq_side;
    assign n_clamped = (sq_root == '0) ? NW'(1) : sq_root;

    // SN: unit-vector numerators
    logic              sn_valid_reg;
    logic [NW-1:0]     sn_n_reg;
    logic [RbNumW-1:0] sn_num_reg [3];
    logic [2:0]        sn_nr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sn_valid_reg <= 1'b0;
        end else if (en) begin
            sn_valid_reg <= sq_valid && !sq_pad;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sn_n_reg  <= n_clamped;
            sn_nr_reg <= sq_nr;
            for (int i = 0; i < 3; i++) begin
                sn_num_reg[i] <= {sq_ar[i], 30'b0} + RbNumW'(n_clamped >> 1);
            end
        end
    end

    // unit vector magnitudes
    logic [MW-1:0] rb_m [3];
    logic [2:0]    rb_nr;
    logic [2:0]    rb_lane_valid;
    logic          rb_n_valid;
    logic [NW-1:0] rb_n;

    for (genvar i = 0; i < 3; i++) begin : g_rb
        mfe_div #(.NUM_W(RbNumW), .DEN_W(NW), .Q_W(MW), .SIDE_W(1)) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (sn_valid_reg),
            .num_in    (sn_num_reg[i]),
            .den_in    (sn_n_reg),
            .side_in   (sn_nr_reg[i]),
            .valid_out (rb_lane_valid[i]),
            .q_out     (rb_m[i]),
            .side_out  (rb_nr[i])
        );
    end

    mfe_delay #(.W(NW), .DEPTH(MW)) u_n_dly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (sn_valid_reg),
        .data_in   (sn_n_reg),
        .valid_out (rb_n_valid),
        .data_out  (rb_n)
    );

    // P1, P2: products and rounding
    logic              p1_valid_reg, p2_valid_reg;
    logic [MkW-1:0]    p1_mk_reg [3];
    logic [PmagW-1:0]  p1_pmag_reg [6];
    logic [5:0]        p1_pneg_reg, p2_pneg_reg;
    logic [2*NW-1:0]   p1_n2_reg;
    logic [NW-1:0]     p1_n_reg;
    logic [2:0]        p1_nr_reg, p2_nr_reg;
    logic [MkW-1:0]    p2_cnum_reg [3];
    logic [CDenW-1:0]  p2_cden_reg;
    logic [QW-1:0]     p2_q_reg [6];
    logic [GDenW-1:0]  p2_den2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= (&rb_lane_valid) && rb_n_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p1_mk_reg[i]   <= MkW'(rb_m[i]) * MkW'(mfe_pkg::INV4PI_Q32);
                p2_cnum_reg[i] <= p1_mk_reg[i] + MkW'({p1_n_reg, 13'b0});
            end
            for (int k = 0; k < 6; k++) begin
                p1_pmag_reg[k] <= PmagW'(rb_m[PA[k]]) * PmagW'(rb_m[PB[k]]);
                p1_pneg_reg[k] <= (rb_nr[PA[k]] ^ rb_nr[PB[k]])
                                  && (rb_m[PA[k]] != '0) && (rb_m[PB[k]] != '0);
                p2_q_reg[k]    <= QW'((p1_pmag_reg[k] + (PmagW'(1) << 28)) >> 29);
            end
            p1_n2_reg   <= (2*NW)'(rb_n) * (2*NW)'(rb_n);
            p1_n_reg    <= rb_n;
            p1_nr_reg   <= rb_nr;
            p2_cden_reg <= {p1_n_reg, 14'b0};
            p2_den2_reg <= {p1_n2_reg, 6'b0};
            p2_pneg_reg <= p1_pneg_reg;
            p2_nr_reg   <= p1_nr_reg;
        end
    end

    // coefficient division
    logic [CQW-1:0] cq [3];
    logic [2:0]     cq_nr;
    logic [2:0]     cq_valid;

    for (genvar i = 0; i < 3; i++) begin : g_coef
        mfe_div #(.NUM_W(MkW), .DEN_W(CDenW), .Q_W(CQW), .SIDE_W(1)) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (p2_valid_reg),
            .num_in    (p2_cnum_reg[i]),
            .den_in    (p2_cden_reg),
            .side_in   (p2_nr_reg[i]),
            .valid_out (cq_valid[i]),
            .q_out     (cq[i]),
            .side_out  (cq_nr[i])
        );
    end

    // C1, C2: pressure
    logic           c1_valid_reg, c2_valid_reg;
    logic [CQW-1:0] c1_coef_reg [3];
    logic [CQW-1:0] c2_coef_reg [3];
    logic [PlW-1:0] c1_pl_reg [3];
    logic [PhW-1:0] c1_ph_reg [3];
    logic [MagW-1:0] c2_pmag_reg [3];
    logic [2:0]     c1_nr_reg, c2_nr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end else if (en) begin
            c1_valid_reg <= &cq_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c1_coef_reg[i] <= cq[i];
                c1_pl_reg[i]   <= PlW'(smag_reg) * PlW'(cq[i][23:0]);
                c1_ph_reg[i]   <= PhW'(smag_reg) * PhW'(cq[i][CQW-1:24]);
                c2_coef_reg[i] <= c1_coef_reg[i];
                c2_pmag_reg[i] <= MagW'((PsumW'({c1_ph_reg[i], 24'b0}) + PsumW'(c1_pl_reg[i])
                                        + (PsumW'(1) << 15)) >> 16);
            end
            c1_nr_reg <= cq_nr;
            c2_nr_reg <= c1_nr_reg;
        end
    end

    logic            dc_valid;
    logic [DlyW-1:0] dc_data;
    logic [CQW-1:0]  dc_coef [3];
    logic [MagW-1:0] dc_pmag [3];
    logic [2:0]      dc_nr;

    mfe_delay #(.W(DlyW), .DEPTH(3)) u_coef_dly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (c2_valid_reg),
        .data_in   ({c2_coef_reg[0], c2_coef_reg[1], c2_coef_reg[2],
                     c2_pmag_reg[0], c2_pmag_reg[1], c2_pmag_reg[2], c2_nr_reg}),
        .valid_out (dc_valid),
        .data_out  (dc_data)
    );

    assign {dc_coef[0], dc_coef[1], dc_coef[2], dc_pmag[0], dc_pmag[1], dc_pmag[2], dc_nr}
        = dc_data;

    // P3..P6: gradient numerators
    logic             p3_valid_reg, p4_valid_reg, p5_valid_reg, p6_valid_reg;
    logic [5:0]       p3_mneg_reg, p4_mneg_reg, p5_mneg_reg, p6_mneg_reg;
    logic [MmagW-1:0] p3_mmag_reg [6];
    logic [GlW-1:0]   p4_gl_reg [6];
    logic [GhW-1:0]   p4_gh_reg [6];
    logic [GNumW-1:0] p5_gnum_reg [6];
    logic [GNumW-1:0] p6_num_reg [6];
    logic [5:0]       p6_ovf_reg;
    logic [GDenW-1:0] p3_den2_reg, p4_den2_reg, p5_den2_reg, p6_den2_reg;
    logic [5:0]       ovf_next;

    localparam logic [QW-1:0] One30 = QW'(1) << 30;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            ovf_next[k] = (GDenW'(p5_gnum_reg[k][GNumW-1:GQW]) >= p5_den2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                if (k < 3) begin
                    p3_mneg_reg[k] <= (p2_q_reg[k] > One30);
                    p3_mmag_reg[k] <= (p2_q_reg[k] > One30) ? MmagW'(p2_q_reg[k] - One30)
                                                            : MmagW'(One30 - p2_q_reg[k]);
                end else begin
                    p3_mneg_reg[k] <= !p2_pneg_reg[k] && (p2_q_reg[k] != '0);
                    p3_mmag_reg[k] <= MmagW'(p2_q_reg[k]);
                end
                p4_gl_reg[k]   <= GlW'(gk_reg[29:0]) * GlW'(p3_mmag_reg[k]);
                p4_gh_reg[k]   <= GhW'(gk_reg[GkW-1:30]) * GhW'(p3_mmag_reg[k]);
                p5_gnum_reg[k] <= GNumW'((GNumW+1)'({p4_gh_reg[k], 30'b0})
                                         + (GNumW+1)'(p4_gl_reg[k])
                                         + (GNumW+1)'(p4_den2_reg >> 1));
                p6_num_reg[k]  <= ovf_next[k] ? '0 : p5_gnum_reg[k];
            end
            p4_mneg_reg <= p3_mneg_reg;
            p5_mneg_reg <= p4_mneg_reg;
            p6_mneg_reg <= p5_mneg_reg;
            p6_ovf_reg  <= ovf_next;
            p3_den2_reg <= p2_den2_reg;
            p4_den2_reg <= p3_den2_reg;
            p5_den2_reg <= p4_den2_reg;
            p6_den2_reg <= p5_den2_reg;
        end
    end

    // gradient division
    logic [GQW-1:0] gq [6];
    logic [5:0]     gq_mneg, gq_ovf, gq_valid;

    for (genvar k = 0; k < 6; k++) begin : g_grad
        mfe_div #(.NUM_W(GNumW), .DEN_W(GDenW), .Q_W(GQW), .SIDE_W(2)) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (p6_valid_reg),
            .num_in    (p6_num_reg[k]),
            .den_in    (p6_den2_reg),
            .side_in   ({p6_mneg_reg[k], p6_ovf_reg[k]}),
            .valid_out (gq_valid[k]),
            .q_out     (gq[k]),
            .side_out  ({gq_mneg[k], gq_ovf[k]})
        );
    end

    // output register
    logic [OW-1:0] gout [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            gout[k] = sat_pack(sneg_reg == gq_mneg[k],
                               gq_ovf[k] ? SatNeg : MagW'(gq[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dc_valid && (&gq_valid);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg.coef_x     <= sat_pack(dc_nr[0], MagW'(dc_coef[0]));
            out_data_reg.coef_y     <= sat_pack(dc_nr[1], MagW'(dc_coef[1]));
            out_data_reg.coef_z     <= sat_pack(dc_nr[2], MagW'(dc_coef[2]));
            out_data_reg.pressure_x <= sat_pack(sneg_reg ^ dc_nr[0], dc_pmag[0]);
            out_data_reg.pressure_y <= sat_pack(sneg_reg ^ dc_nr[1], dc_pmag[1]);
            out_data_reg.pressure_z <= sat_pack(sneg_reg ^ dc_nr[2], dc_pmag[2]);
            out_data_reg.grad_xx    <= gout[0];
            out_data_reg.grad_yy    <= gout[1];
            out_data_reg.grad_zz    <= gout[2];
            out_data_reg.grad_xy    <= gout[3];
            out_data_reg.grad_xz    <= gout[4];
            out_data_reg.grad_yz    <= gout[5];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* sv/mfe_checker.sv */
// Port-level assertions for the monopole field evaluator, bound to the top level.
module mfe_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input mfe_pkg::mfe_in_t             s_data,
    input logic                         m_valid,
    input logic                         m_ready,
    input mfe_pkg::mfe_out_t            m_data,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [mfe_pkg::CfgIdxW-1:0]  cfg_index,
    input logic [mfe_pkg::CfgDataW-1:0] cfg_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_zero_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.coef_x != '0 || m_data.pressure_x == '0))
        else $error("pressure without coefficient");

endmodule

bind monopole_field_evaluator_core mfe_checker u_mfe_checker (.*);

/* verif/monopole_field_evaluator_core_tb.sv */
// Self-checking testbench for the monopole field evaluator core.
`timescale 1ns / 1ps

module monopole_field_evaluator_core_tb;

    localparam logic [mfe_pkg::CfgIdxW-1:0] CFG_SPARE_IDX = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 140;
    localparam logic [127:0] SAT_MAG = 128'h8000_0000_0000;

    class field_scoreboard;
        logic signed [mfe_pkg::CoordW-1:0] cen [3];
        logic signed [mfe_pkg::CfgDataW-1:0] strength;
        mfe_pkg::mfe_out_t expected_q [$];
        int errors;
        int checked;
        string names [12];

        function new();
            cen = '{0, 0, 0};
            strength = mfe_pkg::STRENGTH_RESET;
            names = '{"coef_x", "coef_y", "coef_z", "pressure_x", "pressure_y",
                      "pressure_z", "grad_xx", "grad_yy", "grad_zz", "grad_xy",
                      "grad_xz", "grad_yz"};
        endfunction

        function void set_reg(logic [mfe_pkg::CfgIdxW-1:0] idx,
                              logic [mfe_pkg::CfgDataW-1:0] val);
            case (idx)
                mfe_pkg::CFG_CENTER_X: cen[0] = val;
                mfe_pkg::CFG_CENTER_Y: cen[1] = val;
                mfe_pkg::CFG_CENTER_Z: cen[2] = val;
                mfe_pkg::CFG_STRENGTH: strength = val;
                default: ;
            endcase
        endfunction

        function logic [127:0] round_div(logic [127:0] num, logic [127:0] den);
            logic [127:0] q;
            q = (num + (den >> 1)) / den;
            return (q > SAT_MAG) ? SAT_MAG : q;
        endfunction

        function logic [mfe_pkg::OutW-1:0] saturate(bit neg, logic [127:0] mag);
            logic [127:0] v;
            if (neg) begin
                v = (mag > SAT_MAG) ? SAT_MAG : mag;
                return mfe_pkg::OutW'(-v);
            end
            return (mag > SAT_MAG - 1) ? mfe_pkg::OutW'(SAT_MAG - 1) : mfe_pkg::OutW'(mag);
        endfunction

        function mfe_pkg::mfe_out_t field_at(mfe_pkg::mfe_in_t p);
            longint r [3];
            longint rb [3];
            longint prod, mterm, s;
            bit nr [3];
            bit sneg, mneg;
            logic [127:0] ar [3];
            logic [127:0] coefm [3];
            logic [127:0] sum, n, cand, m, smag, gk, den2, q, mmag;
            logic [mfe_pkg::OutW*12-1:0] flat;
            int a, b;
            r[0] = longint'(p.point_x) - longint'(cen[0]);
            r[1] = longint'(p.point_y) - longint'(cen[1]);
            r[2] = longint'(p.point_z) - longint'(cen[2]);
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                nr[i] = r[i] < 0;
                ar[i] = nr[i] ? 128'(-r[i]) : 128'(r[i]);
                sum += ar[i] * ar[i];
            end
            n = 0;
            for (int k = 34; k >= 0; k--) begin
                cand = n | (128'd1 << k);
                if (cand * cand <= sum) n = cand;
            end
            if (n == 0) n = 1;
            s = longint'(strength);
            sneg = s < 0;
            smag = sneg ? 128'(-s) : 128'(s);
            for (int i = 0; i < 3; i++) begin
                m = ((ar[i] << 30) + (n >> 1)) / n;
                rb[i] = nr[i] ? -longint'(m) : longint'(m);
                coefm[i] = round_div(m * mfe_pkg::INV4PI_Q32, n << 14);
                flat[(11-i)*mfe_pkg::OutW +: mfe_pkg::OutW] = saturate(nr[i], coefm[i]);
                flat[(8-i)*mfe_pkg::OutW +: mfe_pkg::OutW] =
                    saturate(sneg != nr[i], round_div(smag * coefm[i], 128'd65536));
            end
            gk = smag * mfe_pkg::INV4PI_Q32;
            den2 = (n * n) << 6;
            for (int i = 0; i < 6; i++) begin
                a = (i < 3) ? i : ((i == 5) ? 1 : 0);
                b = (i < 3) ? i : ((i == 3) ? 1 : 2);
                prod = rb[a] * rb[b];
                q = ((prod < 0 ? 128'(-prod) : 128'(prod)) + (128'd1 << 28)) >> 29;
                if (i < 3) mterm = (longint'(1) << 30) - longint'(q);
                else mterm = (prod < 0) ? longint'(q) : -longint'(q);
                mneg = mterm < 0;
                mmag = mneg ? 128'(-mterm) : 128'(mterm);
                flat[(5-i)*mfe_pkg::OutW +: mfe_pkg::OutW] =
                    saturate(!(sneg != mneg), round_div(gk * mmag, den2));
            end
            return mfe_pkg::mfe_out_t'(flat);
        endfunction

        function void note_point(mfe_pkg::mfe_in_t p);
            expected_q.push_back(field_at(p));
        endfunction

        function void check_result(mfe_pkg::mfe_out_t got);
            mfe_pkg::mfe_out_t exp_v;
            logic [mfe_pkg::OutW*12-1:0] e, g;
            if (expected_q.size() == 0) begin
                $error("result transfer with no expected result pending");
                errors++;
                return;
            end
            exp_v = expected_q.pop_front();
            e = exp_v;
            g = got;
            checked++;
            for (int k = 0; k < 12; k++)
                if (e[(11-k)*mfe_pkg::OutW +: mfe_pkg::OutW]
                    !== g[(11-k)*mfe_pkg::OutW +: mfe_pkg::OutW]) begin
                    $error("%s mismatch: expected %h actual %h", names[k],
                           e[(11-k)*mfe_pkg::OutW +: mfe_pkg::OutW],
                           g[(11-k)*mfe_pkg::OutW +: mfe_pkg::OutW]);
                    errors++;
                end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    mfe_pkg::mfe_in_t s_data;
    mfe_pkg::mfe_out_t m_data;
    logic [mfe_pkg::CfgIdxW-1:0] cfg_index;
    logic [mfe_pkg::CfgDataW-1:0] cfg_data;

    field_scoreboard sb;
    bit idling_on;
    int stall_left;
    int quiet_cycles;
    int points_sent;
    int cfg_writes;

    monopole_field_evaluator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 5);
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_point(mfe_pkg::mfe_in_t p);
        s_data = p;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_point(p);
        points_sent++;
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
    endtask

    task automatic write_reg(logic [mfe_pkg::CfgIdxW-1:0] idx,
                             logic [mfe_pkg::CfgDataW-1:0] val);
        s_valid = 1'b0;
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic set_source(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] st);
        wait_drained();
        write_reg(mfe_pkg::CFG_CENTER_X, x);
        write_reg(mfe_pkg::CFG_CENTER_Y, y);
        write_reg(mfe_pkg::CFG_CENTER_Z, z);
        write_reg(mfe_pkg::CFG_STRENGTH, st);
    endtask

    function automatic logic [31:0] near(logic [31:0] c);
        logic [31:0] off;
        off = 32'($signed($urandom_range(0, 4095)) - 2048) <<< $urandom_range(0, 26);
        return c + off;
    endfunction

    function automatic mfe_pkg::mfe_in_t rand_point();
        mfe_pkg::mfe_in_t p;
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 7) begin
            p.point_x = $urandom; p.point_y = $urandom; p.point_z = $urandom;
        end else if (kind < 16) begin
            p.point_x = near(sb.cen[0]);
            p.point_y = near(sb.cen[1]);
            p.point_z = near(sb.cen[2]);
        end else if (kind < 19) begin
            p = {sb.cen[0], sb.cen[1], sb.cen[2]};
            case ($urandom_range(0, 2))
                0: p.point_x = near(sb.cen[0]);
                1: p.point_y = near(sb.cen[1]);
                default: p.point_z = near(sb.cen[2]);
            endcase
        end else begin
            p = {sb.cen[0], sb.cen[1], sb.cen[2]};
        end
        return p;
    endfunction

    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idling_on = 1'b1;
        stall_left = 0;
        quiet_cycles = 0;
        points_sent = 0;
        cfg_writes = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_point('{0, 0, 0});
        send_point('{32'd1, 32'd0, 32'd0});
        send_point('{32'd0, -32'sd1, 32'd0});
        send_point('{32'd0, 32'd0, 32'd1});
        send_point('{32'd1, 32'd1, 32'd1});
        send_point('{MAXV, MAXV, MAXV});
        send_point('{MINV, MINV, MINV});
        send_point('{MAXV, MINV, 32'd0});
        send_point('{32'h0100_0000, 32'd0, 32'd0});
        send_point('{32'h0100_0000, 32'h0100_0000, 32'hFF00_0000});
        send_point('{32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFD});
        wait_drained();
        write_reg(CFG_SPARE_IDX, 32'hDEAD_BEEF);
        set_source(MAXV, MAXV, MAXV, MAXV);
        send_point('{MINV, MINV, MINV});
        send_point('{MAXV, MAXV, MAXV});
        send_point('{MAXV, MAXV, 32'h7FFF_FFFE});
        set_source(MINV, MINV, MINV, MINV);
        send_point('{MINV, MINV, MINV});
        send_point('{MAXV, MAXV, MAXV});
        send_point('{MINV, 32'h8000_0001, MINV});
        set_source(32'd0, 32'd0, 32'd0, 32'd0);
        send_point('{0, 0, 0});
        send_point('{32'd5, 32'd7, 32'd0});

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_source(32'd0, 32'd0, 32'd0, mfe_pkg::STRENGTH_RESET);
                1: set_source(MAXV, MINV, 32'd0, MAXV);
                2: set_source(MINV, MAXV, MINV, MINV);
                3: set_source($urandom, $urandom, $urandom, 32'd0);
                default: set_source($urandom, $urandom, $urandom, $urandom);
            endcase
            if (ph == 8) idling_on = 1'b0;
            for (int k = 0; k < 100; k++) begin
                send_point(rand_point());
                if (k == 50 && ph == 4) wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d query points and %0d register writes over 12 source settings,",
                 points_sent, cfg_writes);
        $display("including zero distance, coordinate extremes and zero/extreme strengths.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
